/* hw/rtl/ctfe_pkg.sv */
package ctfe_pkg;

  localparam int unsigned MaxRun = 254;
  localparam int unsigned RunAddrW = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned WordW = 64;
  localparam int unsigned LaneCnt = 8;
  localparam logic [7:0] FullRunCode = 8'hff;
  localparam logic [7:0] EndCode = 8'h01;
  localparam logic [7:0] Delimiter = 8'h00;

  typedef struct packed {
    logic [7:0] topic_id;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_frame;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]  packed_bytes;
    logic [CountW-1:0] byte_count;
    logic              frame_end;
  } out_item_t;

  // work for the back end from one accepted item
  typedef struct packed {
    logic                hdr;
    logic                close;
    logic                fin;
    logic                ended;
    logic [7:0]          tid;
    logic [RunAddrW-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic                en;
    logic [RunAddrW-1:0] addr;
    logic [7:0]          data;
  } run_wr_t;

endpackage

/* hw/rtl/ctfe_front.sv */
module ctfe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ctfe_pkg::in_item_t item_i,
  input  logic               fifo_full_i,
  input  logic               close_done_i,
  output logic               full_o,
  output logic               cmd_push_o,
  output ctfe_pkg::cmd_t     cmd_o,
  output ctfe_pkg::run_wr_t  run_wr_o
);
  import ctfe_pkg::*;

  logic                in_frame_q, in_frame_d;
  logic [RunAddrW-1:0] run_len_q, run_len_d;
  logic                busy_q, busy_d;
  logic                accept;
  logic [RunAddrW-1:0] rl, rl1;
  cmd_t                cmd;

  assign full_o = busy_q | fifo_full_i;
  assign accept = push_i & ~full_o;

  always_comb begin
    cmd        = '0;
    cmd.hdr    = ~in_frame_q;
    cmd.tid    = item_i.topic_id;
    rl         = in_frame_q ? run_len_q : '0;
    rl1        = rl + RunAddrW'(1);
    run_len_d  = run_len_q;
    in_frame_d = in_frame_q;
    run_wr_o   = '0;
    if (accept) begin
      if (item_i.empty_frame) begin
        cmd.close = 1'b1;
        cmd.len   = rl;
        cmd.ended = 1'b1;
      end else if (item_i.data_byte == 8'h00) begin
        cmd.close = 1'b1;
        cmd.len   = rl;
        cmd.fin   = item_i.last_byte;
        cmd.ended = item_i.last_byte;
      end else begin
        run_wr_o.en   = 1'b1;
        run_wr_o.addr = rl;
        run_wr_o.data = item_i.data_byte;
        if (rl1 == RunAddrW'(MaxRun) || item_i.last_byte) begin
          cmd.close = 1'b1;
          cmd.len   = rl1;
          cmd.ended = item_i.last_byte;
        end
      end
      run_len_d  = cmd.close ? '0 : rl1;
      in_frame_d = ~cmd.ended;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept & (cmd.hdr | cmd.close);

  always_comb begin
    busy_d = busy_q;
    if (cmd_push_o && cmd.close) begin
      busy_d = 1'b1;
    end else if (close_done_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      run_len_q  <= '0;
      busy_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      run_len_q  <= run_len_d;
      busy_q     <= busy_d;
    end
  end

endmodule

/* hw/rtl/ctfe_cmd_fifo.sv */
module ctfe_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctfe_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ctfe_pkg::cmd_t data_o
);
  import ctfe_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hw/rtl/ctfe_back.sv */
module ctfe_back #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctfe_pkg::run_wr_t   run_wr_i,
  input  logic                cmd_empty_i,
  input  ctfe_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                close_done_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ctfe_pkg::out_item_t result_o
);
  import ctfe_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHdr0 = 3'd1;
  localparam logic [2:0] StHdr1 = 3'd2;
  localparam logic [2:0] StCode = 3'd3;
  localparam logic [2:0] StData = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [7:0]          run_mem [MaxRun];
  logic [7:0]          rd_data_q;
  logic [RunAddrW-1:0] rd_addr;

  logic [2:0]          st_q, st_d;
  cmd_t                cmd_q;
  logic [RunAddrW-1:0] idx_q, idx_d;
  logic [WordW-1:0]    acc_q, acc_d;
  logic [CountW-1:0]   acc_cnt_q, acc_cnt_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [7:0]          cur_byte;
  logic                is_last, data_end, completes, adv, load;
  logic [CountW-1:0]   cnt_inc;
  logic [WordW-1:0]    word_with;

  always_ff @(posedge clk_i) begin
    if (run_wr_i.en) begin
      run_mem[run_wr_i.addr] <= run_wr_i.data;
    end
    rd_data_q <= run_mem[rd_addr];
  end

  assign data_end = (idx_q == cmd_q.len - RunAddrW'(1));

  always_comb begin
    cur_byte = Delimiter;
    is_last  = 1'b0;
    case (st_q)
      StHdr0: begin
        cur_byte = Delimiter;
      end
      StHdr1: begin
        cur_byte = cmd_q.tid;
        is_last  = ~cmd_q.close;
      end
      StCode: begin
        cur_byte = (cmd_q.len == RunAddrW'(MaxRun)) ? FullRunCode : cmd_q.len + 8'd1;
        is_last  = (cmd_q.len == '0) & ~cmd_q.fin;
      end
      StData: begin
        cur_byte = rd_data_q;
        is_last  = data_end & ~cmd_q.fin;
      end
      StFin: begin
        cur_byte = EndCode;
        is_last  = 1'b1;
      end
      default: begin
        cur_byte = Delimiter;
        is_last  = 1'b0;
      end
    endcase
  end

  assign cnt_inc   = acc_cnt_q + CountW'(1);
  assign completes = (cnt_inc == CountW'(BYTES_PER_RESULT)) | is_last;
  assign adv       = (st_q != StIdle) & (~completes | ~out_valid_q | pop_i);
  assign load      = (st_q == StIdle) & ~cmd_empty_i;
  assign cmd_pop_o = load;
  assign close_done_o = adv & is_last & cmd_q.close;

  assign rd_addr = (st_q == StData && adv && !data_end) ? idx_q + RunAddrW'(1) : idx_q;

  always_comb begin
    word_with = acc_q;
    for (int i = 0; i < LaneCnt; i++) begin
      if (acc_cnt_q[2:0] == 3'(i)) begin
        word_with[8*i +: 8] = cur_byte;
      end
    end
  end

  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    acc_cnt_d   = acc_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~pop_i;
    if (load) begin
      idx_d = '0;
      st_d  = cmd_i.hdr ? StHdr0 : StCode;
    end
    if (adv) begin
      if (completes) begin
        out_d.packed_bytes = word_with;
        out_d.byte_count   = cnt_inc;
        out_d.frame_end    = cmd_q.ended & is_last;
        out_valid_d        = 1'b1;
        acc_d              = '0;
        acc_cnt_d          = '0;
      end else begin
        acc_d     = word_with;
        acc_cnt_d = cnt_inc;
      end
      case (st_q)
        StHdr0: st_d = StHdr1;
        StHdr1: st_d = cmd_q.close ? StCode : StIdle;
        StCode: begin
          if (cmd_q.len != '0) begin
            st_d = StData;
          end else begin
            st_d = cmd_q.fin ? StFin : StIdle;
          end
        end
        StData: begin
          if (data_end) begin
            st_d = cmd_q.fin ? StFin : StIdle;
          end else begin
            idx_d = idx_q + RunAddrW'(1);
          end
        end
        StFin: st_d = StIdle;
        default: st_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      idx_q       <= '0;
      acc_q       <= '0;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      acc_cnt_q   <= acc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o  = ~out_valid_q;
  assign result_o = out_q;

endmodule

/* hw/rtl/cobs_topic_frame_encoder.sv */
// an item that closes a run queues a command that the back end turns into frame words
// back end emits one frame byte per cycle into an 8-byte word register while the output word is not stalled
// after an item that closes a run, full is held high until the back end has packed the run's last byte
// items that only extend a run are taken every cycle while full is low
// reset clears frame, run and queue state; run store contents stay undefined
module cobs_topic_frame_encoder #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ctfe_pkg::in_item_t  item_i,
  output logic                empty,
  input  logic                pop,
  output ctfe_pkg::out_item_t result_o
);
  import ctfe_pkg::*;

  logic    fifo_full, fifo_empty, cmd_push, cmd_pop, close_done;
  cmd_t    cmd_in, cmd_out;
  run_wr_t run_wr;

  ctfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item_i),
    .fifo_full_i  (fifo_full),
    .close_done_i (close_done),
    .full_o       (full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .run_wr_o     (run_wr)
  );

  ctfe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .empty_o (fifo_empty),
    .data_o  (cmd_out)
  );

  ctfe_back #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_wr_i     (run_wr),
    .cmd_empty_i  (fifo_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .close_done_o (close_done),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );

endmodule

/* hw/rtl/ctfe_checker.sv */
module ctfe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input ctfe_pkg::in_item_t  item_i,
  input logic                empty,
  input logic                pop,
  input ctfe_pkg::out_item_t result_o
);
  import ctfe_pkg::*;

  // a waiting beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> result_o.byte_count != '0 && result_o.byte_count <= CountW'(LaneCnt))
    else $error("byte count out of range");

  // bytes above the count are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.packed_bytes >> (8 * result_o.byte_count)) == '0)
    else $error("stray bytes above count");

  // nothing pending right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> empty && !full)
    else $error("not idle after reset");

endmodule

bind cobs_topic_frame_encoder ctfe_checker u_ctfe_checker (.*);

/* sim/ctfe_word_checker.sv */
module ctfe_word_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  ctfe_pkg::in_item_t  item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  ctfe_pkg::out_item_t result_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctfe_pkg::*;

  logic [7:0]  run_buf [MaxRun];
  int unsigned run_len;
  logic        frame_open;
  logic [7:0]  frame_bytes [$];
  out_item_t   expected_words [$];
  int unsigned fails;

  function automatic void close_run();
    int unsigned i;
    frame_bytes.push_back(8'(run_len + 1));
    for (i = 0; i < run_len; i++) frame_bytes.push_back(run_buf[i]);
    run_len = 0;
  endfunction

  function automatic void encode_beat(in_item_t it);
    logic        ended;
    out_item_t   w;
    int unsigned nwords, k, j, cnt;
    ended = 1'b0;
    frame_bytes.delete();
    if (!frame_open) begin
      frame_bytes.push_back(Delimiter);
      frame_bytes.push_back(it.topic_id);
      frame_open = 1'b1;
      run_len = 0;
    end
    if (it.empty_frame) begin
      close_run();
      ended = 1'b1;
    end else if (it.data_byte == 8'h00) begin
      close_run();
      if (it.last_byte) begin
        frame_bytes.push_back(EndCode);
        ended = 1'b1;
      end
    end else begin
      if (run_len < MaxRun) begin
        run_buf[run_len] = it.data_byte;
        run_len++;
      end
      // full run goes out at once with code ff
      if (run_len >= MaxRun) begin
        close_run();
        if (it.last_byte) ended = 1'b1;
      end else if (it.last_byte) begin
        close_run();
        ended = 1'b1;
      end
    end
    if (ended) frame_open = 1'b0;
    nwords = (frame_bytes.size() + LaneCnt - 1) / LaneCnt;
    for (k = 0; k < nwords; k++) begin
      w = '0;
      cnt = frame_bytes.size() - k * LaneCnt;
      if (cnt > LaneCnt) cnt = LaneCnt;
      for (j = 0; j < cnt; j++) w.packed_bytes[8*j +: 8] = frame_bytes[k * LaneCnt + j];
      w.byte_count = CountW'(cnt);
      w.frame_end  = ended && (k + 1 == nwords);
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      run_len = 0;
      frame_open = 1'b0;
      expected_words.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // output beat first: it can never come from this edge's input beat
      if (!empty_i && pop_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: packed_bytes %h byte_count %0d frame_end %0b",
                 result_i.packed_bytes, result_i.byte_count, result_i.frame_end);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (result_i.packed_bytes !== want.packed_bytes) begin
            $error("packed_bytes: expected %h, actual %h",
                   want.packed_bytes, result_i.packed_bytes);
            fails++;
          end
          if (result_i.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, actual %0d",
                   want.byte_count, result_i.byte_count);
            fails++;
          end
          if (result_i.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b",
                   want.frame_end, result_i.frame_end);
            fails++;
          end
        end
      end
      if (push_i && !full_i) encode_beat(item_i);
      pending_o <= expected_words.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* sim/cobs_topic_frame_encoder_tb.sv */
module cobs_topic_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctfe_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  int unsigned fails;
  int unsigned pending;

  int unsigned beats_sent = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic        calm = 1'b0;
  logic        long_a_done = 1'b0;

  always #6 clk_i = ~clk_i;

  cobs_topic_frame_encoder u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result)
  );

  ctfe_word_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .item_i       (item),
    .empty_i      (empty),
    .pop_i        (pop),
    .result_i     (result),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  task automatic offer(input logic [7:0] tid, input logic [7:0] data, input logic last,
                       input logic no_payload);
    in_item_t it;
    it = '{topic_id: tid, data_byte: data, last_byte: last, empty_frame: no_payload};
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    item <= it;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
    if (beats_sent == 10) hold_req = 1'b1;
    if (beats_sent == 250) calm = 1'b1;
  endtask

  task automatic send_random_frame();
    int unsigned n, cut, i;
    logic [7:0]  tid, d;
    if ($urandom_range(0, 6) == 0) begin
      // noise beats
      repeat ($urandom_range(1, 6))
        offer(8'($urandom), ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom),
              1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      return;
    end
    tid = 8'($urandom);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    if (n == 0) begin
      offer(tid, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    if (n >= 2 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, n - 1);
    else cut = n;
    for (i = 0; i < n; i++) begin
      if (i == cut) begin
        // frame cut short by an empty beat
        offer(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        return;
      end
      d = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      offer((i == 0) ? tid : 8'($urandom), d, i == n - 1, 1'b0);
    end
  endtask

  task automatic send_long_frame(input logic with_tail);
    int unsigned i;
    logic [7:0]  tid;
    tid = 8'($urandom);
    for (i = 0; i < MaxRun; i++)
      offer(tid, 8'($urandom_range(1, 255)), !with_tail && i == MaxRun - 1, 1'b0);
    if (with_tail) begin
      offer(tid, 8'h00, 1'b0, 1'b0);
      for (i = 0; i < 3; i++) offer(tid, 8'($urandom_range(1, 255)), i == 2, 1'b0);
    end
  endtask

  initial begin
    #10ms;
    $display("cobs_topic_frame_encoder_tb failed");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the block backs up and stalls its input
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats
    offer(8'h00, 8'h00, 1'b0, 1'b1);
    offer(8'hff, 8'hff, 1'b1, 1'b1);
    offer(8'haa, 8'hff, 1'b1, 1'b0);
    offer(8'h55, 8'h00, 1'b1, 1'b0);
    offer(8'h01, 8'h01, 1'b0, 1'b0);
    offer(8'h02, 8'h00, 1'b0, 1'b0);
    offer(8'h03, 8'hff, 1'b0, 1'b0);
    offer(8'h04, 8'h00, 1'b1, 1'b0);
    offer(8'h80, 8'h12, 1'b0, 1'b0);
    offer(8'h81, 8'h34, 1'b0, 1'b0);
    offer(8'h82, 8'h00, 1'b1, 1'b1);
    offer(8'h01, 8'h80, 1'b0, 1'b0);
    offer(8'h02, 8'h7f, 1'b1, 1'b0);
    for (int i = 1; i <= 9; i++) offer(8'h3c, 8'(i * 28), i == 9, 1'b0);

    // long run part, then random frames
    while (beats_sent < 290) begin
      if (!long_a_done) begin
        long_a_done = 1'b1;
        send_long_frame(1'b1);
      end else begin
        send_random_frame();
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fails == 0) begin
      $display("cobs_topic_frame_encoder_tb passed");
    end else begin
      $display("cobs_topic_frame_encoder_tb failed");
    end
    $finish;
  end

endmodule
